/* src/mer_pkg.sv */
`default_nettype none

package mer_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEMI_AXIS_X = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEMI_AXIS_Y = 2'd3;

  // Multiplier operand selection
  localparam int MUL_BITS = 4;
  localparam logic [MUL_BITS-1:0] MUL_NONE    = 4'd0;
  localparam logic [MUL_BITS-1:0] MUL_AA      = 4'd1;
  localparam logic [MUL_BITS-1:0] MUL_BB      = 4'd2;
  localparam logic [MUL_BITS-1:0] MUL_ASQ_B   = 4'd3;
  localparam logic [MUL_BITS-1:0] MUL_TXTX    = 4'd4;
  localparam logic [MUL_BITS-1:0] MUL_BSQ_P   = 4'd5;
  localparam logic [MUL_BITS-1:0] MUL_TYTY    = 4'd6;
  localparam logic [MUL_BITS-1:0] MUL_ASQ_P   = 4'd7;
  localparam logic [MUL_BITS-1:0] MUL_ASQ_BSQ = 4'd8;

  // Datapath operations
  localparam int ALU_BITS = 4;
  localparam logic [ALU_BITS-1:0] ALU_NONE   = 4'd0;
  localparam logic [ALU_BITS-1:0] ALU_TAKE   = 4'd1;
  localparam logic [ALU_BITS-1:0] ALU_LD_ASQ = 4'd2;
  localparam logic [ALU_BITS-1:0] ALU_LD_BSQ = 4'd3;
  localparam logic [ALU_BITS-1:0] ALU_INIT   = 4'd4;
  localparam logic [ALU_BITS-1:0] ALU_D_LD   = 4'd5;
  localparam logic [ALU_BITS-1:0] ALU_D_ADD4 = 4'd6;
  localparam logic [ALU_BITS-1:0] ALU_D_SUB4 = 4'd7;
  localparam logic [ALU_BITS-1:0] ALU_MOVE   = 4'd8;
  localparam logic [ALU_BITS-1:0] ALU_SETTLE = 4'd9;
  localparam logic [ALU_BITS-1:0] ALU_EMIT   = 4'd10;

  // Jump conditions
  localparam int COND_BITS = 3;
  localparam logic [COND_BITS-1:0] C_NEVER    = 3'd0;
  localparam logic [COND_BITS-1:0] C_ALWAYS   = 3'd1;
  localparam logic [COND_BITS-1:0] C_NO_ITEM  = 3'd2;
  localparam logic [COND_BITS-1:0] C_ADVANCE  = 3'd3;
  localparam logic [COND_BITS-1:0] C_NOT_WALK = 3'd4;
  localparam logic [COND_BITS-1:0] C_IN_R1    = 3'd5;
  localparam logic [COND_BITS-1:0] C_OUT_BUSY = 3'd6;

  // Program addresses
  localparam int UPC_BITS = 5;
  localparam logic [UPC_BITS-1:0] U_S0   = 5'd0;
  localparam logic [UPC_BITS-1:0] U_S1   = 5'd1;
  localparam logic [UPC_BITS-1:0] U_E0   = 5'd2;
  localparam logic [UPC_BITS-1:0] U_E1   = 5'd3;
  localparam logic [UPC_BITS-1:0] U_E2   = 5'd4;
  localparam logic [UPC_BITS-1:0] U_E3   = 5'd5;
  localparam logic [UPC_BITS-1:0] U_E4   = 5'd6;
  localparam logic [UPC_BITS-1:0] U_E5   = 5'd7;
  localparam logic [UPC_BITS-1:0] U_T0   = 5'd8;
  localparam logic [UPC_BITS-1:0] U_T1   = 5'd9;
  localparam logic [UPC_BITS-1:0] U_P0   = 5'd10;
  localparam logic [UPC_BITS-1:0] U_P1   = 5'd11;
  localparam logic [UPC_BITS-1:0] U_P2   = 5'd12;
  localparam logic [UPC_BITS-1:0] U_P3   = 5'd13;
  localparam logic [UPC_BITS-1:0] U_IDLE = 5'd14;
  localparam logic [UPC_BITS-1:0] U_DISP = 5'd15;
  localparam logic [UPC_BITS-1:0] U_R0   = 5'd16;
  localparam logic [UPC_BITS-1:0] U_R1   = 5'd17;
  localparam logic [UPC_BITS-1:0] U_R2   = 5'd18;
  localparam logic [UPC_BITS-1:0] U_R3   = 5'd19;

  typedef struct packed {
    logic [MUL_BITS-1:0]  mul;
    logic [ALU_BITS-1:0]  alu;
    logic [COND_BITS-1:0] cond;
    logic [1:0]           quad;
    logic [UPC_BITS-1:0]  target;
  } ucode_t;

  // Control store: jump to target when cond holds, else fall through
  function automatic ucode_t ucode_rom(input logic [UPC_BITS-1:0] addr);
    ucode_t w;
    case (addr)
      U_S0:    w = '{MUL_NONE,    ALU_NONE,   C_NOT_WALK, 2'd0, U_IDLE};
      U_S1:    w = '{MUL_NONE,    ALU_NONE,   C_IN_R1,    2'd0, U_T0};
      U_E0:    w = '{MUL_TXTX,    ALU_NONE,   C_NEVER,    2'd0, U_IDLE};
      U_E1:    w = '{MUL_BSQ_P,   ALU_NONE,   C_NEVER,    2'd0, U_IDLE};
      U_E2:    w = '{MUL_TYTY,    ALU_D_LD,   C_NEVER,    2'd0, U_IDLE};
      U_E3:    w = '{MUL_ASQ_P,   ALU_NONE,   C_NEVER,    2'd0, U_IDLE};
      U_E4:    w = '{MUL_ASQ_BSQ, ALU_D_ADD4, C_NEVER,    2'd0, U_IDLE};
      U_E5:    w = '{MUL_NONE,    ALU_D_SUB4, C_NEVER,    2'd0, U_IDLE};
      U_T0:    w = '{MUL_NONE,    ALU_MOVE,   C_NEVER,    2'd0, U_IDLE};
      U_T1:    w = '{MUL_NONE,    ALU_SETTLE, C_NEVER,    2'd0, U_IDLE};
      U_P0:    w = '{MUL_NONE,    ALU_EMIT,   C_OUT_BUSY, 2'd0, U_P0};
      U_P1:    w = '{MUL_NONE,    ALU_EMIT,   C_OUT_BUSY, 2'd1, U_P1};
      U_P2:    w = '{MUL_NONE,    ALU_EMIT,   C_OUT_BUSY, 2'd2, U_P2};
      U_P3:    w = '{MUL_NONE,    ALU_EMIT,   C_OUT_BUSY, 2'd3, U_P3};
      U_IDLE:  w = '{MUL_NONE,    ALU_TAKE,   C_NO_ITEM,  2'd0, U_IDLE};
      U_DISP:  w = '{MUL_NONE,    ALU_NONE,   C_ADVANCE,  2'd0, U_S0};
      U_R0:    w = '{MUL_AA,      ALU_NONE,   C_NEVER,    2'd0, U_IDLE};
      U_R1:    w = '{MUL_BB,      ALU_LD_ASQ, C_NEVER,    2'd0, U_IDLE};
      U_R2:    w = '{MUL_ASQ_B,   ALU_LD_BSQ, C_NEVER,    2'd0, U_IDLE};
      U_R3:    w = '{MUL_NONE,    ALU_INIT,   C_ALWAYS,   2'd0, U_IDLE};
      default: w = '{MUL_NONE,    ALU_NONE,   C_ALWAYS,   2'd0, U_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* src/mer_if.sv */
`default_nettype none

interface mer_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface mer_out_if #(
  parameter int PIX_BITS = 14
);
  logic                       valid;
  logic                       ready;
  logic signed [PIX_BITS-1:0] pixel_x;
  logic signed [PIX_BITS-1:0] pixel_y;
  logic                       last_of_step;
  logic                       ellipse_done;

  modport source (output valid, output pixel_x, output pixel_y, output last_of_step,
                  output ellipse_done, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input last_of_step,
                input ellipse_done, output ready);
endinterface

interface mer_cfg_if #(
  parameter int DATA_BITS = 12
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           index;
  logic [DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/midpoint_ellipse_rasterizer_unit.sv */
`default_nettype none

// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   restart
// out_ch   out  valid/ready   pixel_x, pixel_y, last_of_step, ellipse_done
// cfg_ch   in   valid/ready   index, data (ready always high)
//
// A microprogram runs one step per cycle around a single shared multiplier.
// Restart item runs R0..R3. Advance item runs S0, S1, T0, T1 and P0..P3, with E0..E5
// added on the step that enters region two; it returns from S0 when no walk is active.
// The four pixels leave through one output register; a stall holds the emit step.
// Reset (rst_n low, synchronous) parks the sequencer at idle, clears the walk,
// sets the center to 0 and both semi-axes to 1.
module midpoint_ellipse_rasterizer_unit #(
  parameter int AXIS_BITS  = 10,
  parameter int COORD_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch,
  mer_cfg_if.sink   cfg_ch
);
  import mer_pkg::*;

  localparam int PIX_BITS = COORD_BITS + 2;
  localparam int X_BITS   = AXIS_BITS + 1;
  localparam int TX_BITS  = X_BITS + 1;
  localparam int SQ_BITS  = 2 * AXIS_BITS;
  localparam int MA_BITS  = SQ_BITS;
  localparam int MB_BITS  = 2 * TX_BITS;
  localparam int P_BITS   = MA_BITS + MB_BITS;
  localparam int DEC_BITS = P_BITS + 4;
  localparam int PQ_BITS  = 3 * AXIS_BITS + 2;

  // Configuration registers
  logic [COORD_BITS-1:0] center_x_r, center_y_r;
  logic [AXIS_BITS-1:0]  axis_x_r, axis_y_r;

  // Sequencer
  logic [UPC_BITS-1:0] upc_r, upc_nxt;
  ucode_t              uc;
  logic                cond_true;

  // Datapath
  logic [P_BITS-1:0]   p_r, p_nxt;
  logic [SQ_BITS-1:0]  asq_r, asq_nxt, bsq_r, bsq_nxt;
  logic [X_BITS-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic [PQ_BITS-1:0]  px_r, px_nxt, py_r, py_nxt;
  logic [DEC_BITS-1:0] d_r, d_nxt;
  logic                region_r, region_nxt;
  logic                walking_r, walking_nxt;
  logic                restart_r, restart_nxt;
  logic                dx_r, dx_nxt, dy_r, dy_nxt;
  logic                done_r, done_nxt;
  logic [MA_BITS-1:0]  ma;
  logic [MB_BITS-1:0]  mb;
  logic [TX_BITS-1:0]  tx;
  logic [X_BITS-1:0]   ty;
  logic                neg;
  logic                neg_x, neg_y;

  // Output register
  logic                       out_valid_r, out_valid_nxt;
  logic signed [PIX_BITS-1:0] pix_x_r, pix_x_nxt, pix_y_r, pix_y_nxt;
  logic                       last_r, last_nxt, edone_r, edone_nxt;
  logic                       out_free;

  assign uc       = ucode_rom(upc_r);
  assign out_free = !out_valid_r || out_ch.ready;
  assign tx       = {x_r, 1'b1};
  assign ty       = y_r - X_BITS'(1);
  assign neg      = d_r[DEC_BITS-1];

  assign in_ch.ready         = (upc_r == U_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = pix_x_r;
  assign out_ch.pixel_y      = pix_y_r;
  assign out_ch.last_of_step = last_r;
  assign out_ch.ellipse_done = edone_r;

  always_comb begin
    case (uc.cond)
      C_NEVER:    cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_NO_ITEM:  cond_true = !in_ch.valid;
      C_ADVANCE:  cond_true = !restart_r;
      C_NOT_WALK: cond_true = !walking_r;
      C_IN_R1:    cond_true = region_r || (px_r < py_r);
      C_OUT_BUSY: cond_true = !out_free;
      default:    cond_true = 1'b0;
    endcase
    upc_nxt = cond_true ? uc.target : upc_r + UPC_BITS'(1);
  end

  // Shared multiplier, product registered in p_r
  always_comb begin
    case (uc.mul)
      MUL_AA: begin
        ma = MA_BITS'(axis_x_r);
        mb = MB_BITS'(axis_x_r);
      end
      MUL_BB: begin
        ma = MA_BITS'(axis_y_r);
        mb = MB_BITS'(axis_y_r);
      end
      MUL_ASQ_B: begin
        ma = asq_r;
        mb = MB_BITS'(axis_y_r);
      end
      MUL_TXTX: begin
        ma = MA_BITS'(tx);
        mb = MB_BITS'(tx);
      end
      MUL_BSQ_P: begin
        ma = bsq_r;
        mb = p_r[MB_BITS-1:0];
      end
      MUL_TYTY: begin
        ma = MA_BITS'(ty);
        mb = MB_BITS'(ty);
      end
      MUL_ASQ_P: begin
        ma = asq_r;
        mb = p_r[MB_BITS-1:0];
      end
      MUL_ASQ_BSQ: begin
        ma = asq_r;
        mb = MB_BITS'(bsq_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    p_nxt = (uc.mul != MUL_NONE) ? P_BITS'(ma) * P_BITS'(mb) : p_r;
  end

  // Pixel sign pattern follows the region's octant order
  always_comb begin
    if (!region_r) begin
      neg_x = uc.quad[0];
      neg_y = uc.quad[1];
    end else begin
      neg_x = ~(uc.quad[0] ^ uc.quad[1]);
      neg_y = ~uc.quad[1];
    end
  end

  always_comb begin
    asq_nxt       = asq_r;
    bsq_nxt       = bsq_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    d_nxt         = d_r;
    region_nxt    = region_r;
    walking_nxt   = walking_r;
    restart_nxt   = restart_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pix_x_nxt     = pix_x_r;
    pix_y_nxt     = pix_y_r;
    last_nxt      = last_r;
    edone_nxt     = edone_r;
    case (uc.alu)
      ALU_NONE: begin
      end
      ALU_TAKE: begin
        if (in_ch.valid) begin
          restart_nxt = in_ch.restart;
        end
      end
      ALU_LD_ASQ: asq_nxt = p_r[SQ_BITS-1:0];
      ALU_LD_BSQ: bsq_nxt = p_r[SQ_BITS-1:0];
      ALU_INIT: begin
        // p_r holds a*a*b here
        x_nxt       = '0;
        y_nxt       = X_BITS'(axis_y_r);
        px_nxt      = '0;
        py_nxt      = PQ_BITS'(p_r);
        region_nxt  = 1'b0;
        walking_nxt = (axis_y_r != '0);
        d_nxt       = DEC_BITS'({bsq_r, 2'b00}) + DEC_BITS'(asq_r)
                    - DEC_BITS'({p_r, 2'b00});
      end
      ALU_D_LD:   d_nxt = DEC_BITS'(p_r);
      ALU_D_ADD4: d_nxt = d_r + DEC_BITS'({p_r, 2'b00});
      ALU_D_SUB4: begin
        d_nxt      = d_r - DEC_BITS'({p_r, 2'b00});
        region_nxt = 1'b1;
      end
      ALU_MOVE: begin
        // Pick the move from the decision sign, add the constant term
        dx_nxt = !region_r || neg;
        dy_nxt = region_r || !neg;
        if (dx_nxt) begin
          x_nxt  = x_r + X_BITS'(1);
          px_nxt = px_r + PQ_BITS'(bsq_r);
        end
        if (dy_nxt) begin
          y_nxt  = y_r - X_BITS'(1);
          py_nxt = py_r - PQ_BITS'(asq_r);
        end
        d_nxt = d_r + DEC_BITS'({(region_r ? asq_r : bsq_r), 2'b00});
      end
      ALU_SETTLE: begin
        d_nxt = d_r + (dx_r ? DEC_BITS'({px_r, 3'b000}) : DEC_BITS'(0))
                    - (dy_r ? DEC_BITS'({py_r, 3'b000}) : DEC_BITS'(0));
        done_nxt = (y_r == '0);
        if (y_r == '0) begin
          walking_nxt = 1'b0;
        end
      end
      ALU_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          pix_x_nxt = neg_x ? PIX_BITS'(center_x_r) - PIX_BITS'(x_r)
                            : PIX_BITS'(center_x_r) + PIX_BITS'(x_r);
          pix_y_nxt = neg_y ? PIX_BITS'(center_y_r) - PIX_BITS'(y_r)
                            : PIX_BITS'(center_y_r) + PIX_BITS'(y_r);
          last_nxt  = (uc.quad == 2'd3);
          edone_nxt = (uc.quad == 2'd3) && done_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= U_IDLE;
      out_valid_r <= 1'b0;
      walking_r   <= 1'b0;
      region_r    <= 1'b0;
      restart_r   <= 1'b0;
      center_x_r  <= '0;
      center_y_r  <= '0;
      axis_x_r    <= AXIS_BITS'(1);
      axis_y_r    <= AXIS_BITS'(1);
    end else begin
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
      walking_r   <= walking_nxt;
      region_r    <= region_nxt;
      restart_r   <= restart_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_CENTER_X:    center_x_r <= cfg_ch.data[COORD_BITS-1:0];
          REG_CENTER_Y:    center_y_r <= cfg_ch.data[COORD_BITS-1:0];
          REG_SEMI_AXIS_X: axis_x_r   <= cfg_ch.data[AXIS_BITS-1:0];
          REG_SEMI_AXIS_Y: axis_y_r   <= cfg_ch.data[AXIS_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    asq_r   <= asq_nxt;
    bsq_r   <= bsq_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    d_r     <= d_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    done_r  <= done_nxt;
    pix_x_r <= pix_x_nxt;
    pix_y_r <= pix_y_nxt;
    last_r  <= last_nxt;
    edone_r <= edone_nxt;
  end

endmodule

`default_nettype wire

/* tb/ellipse_pixel_checker.sv */
`default_nettype none

module ellipse_pixel_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  mer_in_if         in_mon,
  mer_out_if        out_mon,
  mer_cfg_if        cfg_mon,
  output int        fail_count,
  output int        pixels_waiting,
  output int        pixels_checked,
  output int        ellipses_closed
);
  import mer_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int AXIS_BITS  = 10;
  localparam int PIX_BITS   = COORD_BITS + 2;

  typedef struct packed {
    logic signed [PIX_BITS-1:0] x;
    logic signed [PIX_BITS-1:0] y;
    logic                       last;
    logic                       done;
  } pixel_t;

  logic [COORD_BITS-1:0] center_x_q;
  logic [COORD_BITS-1:0] center_y_q;
  logic [AXIS_BITS-1:0]  axis_a_q;
  logic [AXIS_BITS-1:0]  axis_b_q;

  // Walk state, kept modulo 2^64 like the decision term
  logic [63:0] dx;
  logic [63:0] dy;
  logic [63:0] dec;
  logic [63:0] a_sq;
  logic [63:0] b_sq;
  logic        region_two;
  logic        tracing;

  pixel_t pixels_due[$];
  int     errors;
  int     checked;
  int     closed;

  function automatic logic signed [PIX_BITS-1:0] mirror(input logic [63:0] c,
                                                        input logic [63:0] off,
                                                        input logic neg);
    logic [63:0] v;
    v = neg ? c - off : c + off;
    return v[PIX_BITS-1:0];
  endfunction

  function automatic void queue_pixel(input logic neg_x, input logic neg_y,
                                      input logic last, input logic done);
    pixel_t p;
    p.x = mirror(64'(center_x_q), dx, neg_x);
    p.y = mirror(64'(center_y_q), dy, neg_y);
    p.last = last;
    p.done = done;
    pixels_due.push_back(p);
  endfunction

  function automatic void step_walk(input logic restart);
    logic [63:0] tx;
    logic [63:0] ty;
    logic        ended;
    if (restart) begin
      a_sq = 64'(axis_a_q) * 64'(axis_a_q);
      b_sq = 64'(axis_b_q) * 64'(axis_b_q);
      dx = '0;
      dy = 64'(axis_b_q);
      region_two = 1'b0;
      dec = 64'd4 * b_sq + a_sq - 64'd4 * a_sq * 64'(axis_b_q);
      tracing = (axis_b_q != '0);
      return;
    end
    if (!tracing) return;

    // slope passed -1: load the region two decision before stepping
    if (!region_two && !(b_sq * dx < a_sq * dy)) begin
      tx = 64'd2 * dx + 64'd1;
      ty = dy - 64'd1;
      region_two = 1'b1;
      dec = b_sq * tx * tx + 64'd4 * a_sq * ty * ty - 64'd4 * a_sq * b_sq;
    end

    if (!region_two) begin
      if (dec[63]) begin
        dx = dx + 64'd1;
        dec = dec + 64'd4 * (64'd2 * b_sq * dx + b_sq);
      end else begin
        dx = dx + 64'd1;
        dy = dy - 64'd1;
        dec = dec + 64'd4 * (64'd2 * b_sq * dx - 64'd2 * a_sq * dy + b_sq);
      end
    end else begin
      if (dec[63]) begin
        dx = dx + 64'd1;
        dy = dy - 64'd1;
        dec = dec + 64'd4 * (64'd2 * b_sq * dx - 64'd2 * a_sq * dy + a_sq);
      end else begin
        dy = dy - 64'd1;
        dec = dec + 64'd4 * (a_sq - 64'd2 * a_sq * dy);
      end
    end

    ended = (dy == '0);
    if (ended) tracing = 1'b0;

    if (!region_two) begin
      queue_pixel(1'b0, 1'b0, 1'b0, 1'b0);
      queue_pixel(1'b1, 1'b0, 1'b0, 1'b0);
      queue_pixel(1'b0, 1'b1, 1'b0, 1'b0);
      queue_pixel(1'b1, 1'b1, 1'b1, ended);
    end else begin
      queue_pixel(1'b1, 1'b1, 1'b0, 1'b0);
      queue_pixel(1'b0, 1'b1, 1'b0, 1'b0);
      queue_pixel(1'b0, 1'b0, 1'b0, 1'b0);
      queue_pixel(1'b1, 1'b0, 1'b1, ended);
    end
  endfunction

  function automatic void check_pixel(input pixel_t got);
    pixel_t want;
    if (pixels_due.size() == 0) begin
      $display("%0t: pixel with none pending: x=%0d y=%0d last=%0b done=%0b",
               $time, got.x, got.y, got.last, got.done);
      errors++;
      return;
    end
    want = pixels_due.pop_front();
    checked++;
    if (want.done) closed++;
    if (got !== want) begin
      $display({"%0t: pixel mismatch: expected x=%0d y=%0d last=%0b done=%0b,",
                " got x=%0d y=%0d last=%0b done=%0b"},
               $time, want.x, want.y, want.last, want.done,
               got.x, got.y, got.last, got.done);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      center_x_q = '0;
      center_y_q = '0;
      axis_a_q = AXIS_BITS'(1);
      axis_b_q = AXIS_BITS'(1);
      dx = '0;
      dy = '0;
      dec = '0;
      a_sq = '0;
      b_sq = '0;
      region_two = 1'b0;
      tracing = 1'b0;
      pixels_due.delete();
      errors = 0;
      checked = 0;
      closed = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_CENTER_X:    center_x_q = cfg_mon.data[COORD_BITS-1:0];
          REG_CENTER_Y:    center_y_q = cfg_mon.data[COORD_BITS-1:0];
          REG_SEMI_AXIS_X: axis_a_q = cfg_mon.data[AXIS_BITS-1:0];
          REG_SEMI_AXIS_Y: axis_b_q = cfg_mon.data[AXIS_BITS-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) step_walk(in_mon.restart);
      if (out_mon.valid && out_mon.ready)
        check_pixel({out_mon.pixel_x, out_mon.pixel_y, out_mon.last_of_step,
                     out_mon.ellipse_done});
    end
    fail_count <= errors;
    pixels_waiting <= pixels_due.size();
    pixels_checked <= checked;
    ellipses_closed <= closed;
  end

endmodule

`default_nettype wire

/* tb/midpoint_ellipse_rasterizer_unit_test.sv */
`default_nettype none

module midpoint_ellipse_rasterizer_unit_test;
  import mer_pkg::*;

  localparam int ITEM_GOAL     = 420;
  localparam int CALM_FROM     = 340;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 240;
  localparam int SETTLE_CYCLES = 24;

  logic clk = 1'b0;
  logic rst_n;

  mer_in_if  in_ch();
  mer_out_if out_ch();
  mer_cfg_if cfg_ch();

  int fail_count;
  int pixels_waiting;
  int pixels_checked;
  int ellipses_closed;
  int items_sent = 0;
  int cycles = 0;
  bit idling_on = 1'b0;
  bit hold_wanted = 1'b0;

  always #5 clk = ~clk;

  midpoint_ellipse_rasterizer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ellipse_pixel_checker pixel_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_mon         (cfg_ch),
    .fail_count      (fail_count),
    .pixels_waiting  (pixels_waiting),
    .pixels_checked  (pixels_checked),
    .ellipses_closed (ellipses_closed)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Pixel receiver: random back-pressure bursts, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_wanted) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_wanted = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 11) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic offer_step(input logic restart);
    in_ch.valid <= 1'b1;
    in_ch.restart <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic trace(input int steps);
    offer_step(1'b1);
    repeat (steps) offer_step(1'b0);
  endtask

  // Drop valid, wait for every pending pixel, then give trailing items time
  task automatic drain_and_rest();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pixels_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [11:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_shape(input logic [11:0] cx, input logic [11:0] cy,
                           input logic [9:0] a, input logic [9:0] b);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_SEMI_AXIS_X, 12'(a));
    write_reg(REG_SEMI_AXIS_Y, 12'(b));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [11:0] cx;
    logic [11:0] cy;
    logic [9:0]  a;
    logic [9:0]  b;
    int          steps;
    int          pick;
    int          phase;
    bit          noise;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.restart <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_CENTER_X;
    cfg_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // advance before any restart, then the reset shape at the origin
    offer_step(1'b0);
    trace(3);
    drain_and_rest();
    set_shape(12'd4095, 12'd4095, 10'd1023, 10'd1023);
    trace(3);
    drain_and_rest();
    // zero horizontal axis walks a vertical segment
    set_shape(12'd100, 12'd200, 10'd0, 10'd3);
    trace(4);
    drain_and_rest();
    // zero vertical axis: the walk never starts
    set_shape(12'd2048, 12'd17, 10'd5, 10'd0);
    trace(1);
    drain_and_rest();
    // change shape mid-walk: latched squares stay, new center applies
    set_shape(12'd0, 12'd4095, 10'd3, 10'd2);
    trace(3);
    drain_and_rest();
    set_shape(12'd1234, 12'd3000, 10'd9, 10'd7);
    repeat (6) offer_step(1'b0);

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      drain_and_rest();
      idling_on = (items_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      cx = 12'($urandom_range(0, 4095));
      cy = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 7) == 0) cx = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
      if ($urandom_range(0, 7) == 0) cy = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        a = 10'($urandom_range(1, 1023));
        b = 10'($urandom_range(1, 3));
        steps = $urandom_range(10, 40);
      end else if (pick == 1) begin
        a = 10'($urandom_range(1, 3));
        b = 10'($urandom_range(512, 1023));
        steps = $urandom_range(10, 40);
      end else if (pick == 2) begin
        a = '0;
        b = 10'($urandom_range(1, 12));
        steps = b + $urandom_range(1, 3);
      end else if (pick == 3) begin
        a = 10'($urandom_range(1, 12));
        b = '0;
        steps = $urandom_range(1, 3);
      end else begin
        a = 10'($urandom_range(1, 24));
        b = 10'($urandom_range(1, 24));
        steps = a + b + $urandom_range(0, 2);
      end
      noise = ($urandom_range(0, 9) == 0);
      if (phase == 2 || phase == 4) begin
        a = 10'($urandom_range(12, 24));
        b = 10'($urandom_range(12, 24));
        steps = a + b + 2;
        noise = 1'b0;
      end
      set_shape(cx, cy, a, b);
      // receiver holds off while the walk keeps coming, so the block backs up
      if (phase == 2) hold_wanted = 1'b1;
      if (noise) begin
        repeat ($urandom_range(4, 12)) offer_step(1'($urandom_range(0, 1)));
      end else begin
        offer_step(1'b1);
        for (int k = 0; k < steps; k++) begin
          if (phase == 4 && k == steps / 2) begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while (pixels_waiting != 0);
          end
          offer_step($urandom_range(0, 24) == 0);
        end
      end
      phase++;
    end

    idling_on = 1'b0;
    drain_and_rest();
    $display("%0d items over %0d shapes, %0d pixels checked, %0d ellipses closed",
             items_sent, phase + 6, pixels_checked, ellipses_closed);
    $display("shapes covered zero axes, extreme centers and axes, and a mid-walk change");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
